// ===== sv/b24argb_pkg.sv =====
// Shared types and constants for the 24-bit BMP stream decoder.
package b24argb_pkg;

  localparam logic [31:0] MAX_DIM  = 32'd4096;
  localparam logic [31:0] HDR_LEN  = 32'd54;
  localparam logic [5:0]  HDR_LAST = 6'd53;
  localparam logic [15:0] MAGIC_BM = 16'h4D42;  // 'B' then 'M', little-endian
  localparam logic [7:0]  ALPHA    = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_PIXELS = 3'd3,
    PH_PAD    = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PIXEL      = 3'd0,
    KIND_HEADER_OK  = 3'd1,
    KIND_BAD_MAGIC  = 3'd2,
    KIND_BAD_SIZE   = 3'd3,
    KIND_BAD_OFFSET = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [31:0]  argb;
    logic [11:0]  column;
    logic [11:0]  row;
    logic         last;
    logic [12:0]  width;
    logic [12:0]  height;
  } b24argb_res_t;

endpackage

// ===== sv/b24argb_parser.sv =====
// Header parser, offset skip, pixel packing and row/column tracking.
module b24argb_parser
  import b24argb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   data_byte_i,
  input  logic         start_of_file_i,
  output logic         res_valid_o,
  output b24argb_res_t res_o
);

  phase_e      phase_q, phase_d, cur_phase;
  logic [5:0]  hdr_q, hdr_d;
  logic [15:0] magic_q, magic_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] raw_w_q, raw_w_d;
  logic [31:0] raw_h_q, raw_h_d;
  logic [1:0]  trip_q, trip_d;
  logic [15:0] held_q, held_d;
  logic [11:0] col_q, col_d;
  logic [11:0] frow_q, frow_d;
  logic [1:0]  pad_q, pad_d;

  logic [5:0]  hdr_idx;
  logic [12:0] w13, h13, col_nxt, row_nxt;
  logic        w_ok, h_ok, last_px;

  assign w13     = raw_w_q[12:0];
  assign h13     = raw_h_q[12:0];
  assign col_nxt = {1'b0, col_q} + 13'd1;
  assign row_nxt = {1'b0, frow_q} + 13'd1;
  assign last_px = (row_nxt == h13) && (col_nxt == w13);

  always_comb begin
    phase_d     = phase_q;
    hdr_d       = hdr_q;
    magic_d     = magic_q;
    offset_d    = offset_q;
    pos_d       = pos_q;
    raw_w_d     = raw_w_q;
    raw_h_d     = raw_h_q;
    trip_d      = trip_q;
    held_d      = held_q;
    col_d       = col_q;
    frow_d      = frow_q;
    pad_d       = pad_q;
    cur_phase   = phase_q;
    hdr_idx     = hdr_q;
    w_ok        = 1'b0;
    h_ok        = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i) begin
      // start mark wipes everything and this byte is header byte 0
      if (start_of_file_i) begin
        cur_phase = PH_HEADER;
        hdr_d     = '0;
        magic_d   = '0;
        offset_d  = '0;
        pos_d     = '0;
        raw_w_d   = '0;
        raw_h_d   = '0;
        trip_d    = '0;
        held_d    = '0;
        col_d     = '0;
        frow_d    = '0;
        pad_d     = '0;
        phase_d   = PH_HEADER;
      end
      hdr_idx = hdr_d;

      case (cur_phase)
        PH_HEADER: begin
          case (hdr_idx)
            6'd0:  magic_d[7:0]    = data_byte_i;
            6'd1:  magic_d[15:8]   = data_byte_i;
            6'd10: offset_d[7:0]   = data_byte_i;
            6'd11: offset_d[15:8]  = data_byte_i;
            6'd12: offset_d[23:16] = data_byte_i;
            6'd13: offset_d[31:24] = data_byte_i;
            6'd18: raw_w_d[7:0]    = data_byte_i;
            6'd19: raw_w_d[15:8]   = data_byte_i;
            6'd20: raw_w_d[23:16]  = data_byte_i;
            6'd21: raw_w_d[31:24]  = data_byte_i;
            6'd22: raw_h_d[7:0]    = data_byte_i;
            6'd23: raw_h_d[15:8]   = data_byte_i;
            6'd24: raw_h_d[23:16]  = data_byte_i;
            6'd25: raw_h_d[31:24]  = data_byte_i;
            default: ;
          endcase
          hdr_d = hdr_idx + 6'd1;
          pos_d = {26'd0, hdr_d};
          if (hdr_idx == HDR_LAST) begin
            // negative sizes have bit 31 set and fail the upper bound
            w_ok         = (raw_w_d != '0) && (raw_w_d <= MAX_DIM);
            h_ok         = (raw_h_d != '0) && (raw_h_d <= MAX_DIM);
            res_valid_o  = 1'b1;
            res_o.width  = raw_w_d[12:0];
            res_o.height = raw_h_d[12:0];
            phase_d      = PH_DONE;
            if (magic_d != MAGIC_BM) begin
              res_o.kind = KIND_BAD_MAGIC;
            end else if (!w_ok || !h_ok) begin
              res_o.kind = KIND_BAD_SIZE;
            end else if (offset_d < HDR_LEN) begin
              res_o.kind = KIND_BAD_OFFSET;
            end else begin
              res_o.kind = KIND_HEADER_OK;
              phase_d    = (offset_d == HDR_LEN) ? PH_PIXELS : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          pos_d = pos_q + 32'd1;
          if (pos_d == offset_q) begin
            phase_d = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          case (trip_q)
            2'd0: begin
              held_d = {8'd0, data_byte_i};
              trip_d = 2'd1;
            end
            2'd1: begin
              held_d[15:8] = data_byte_i;
              trip_d       = 2'd2;
            end
            default: begin
              trip_d       = 2'd0;
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_PIXEL;
              res_o.argb   = {ALPHA, data_byte_i, held_q};
              res_o.column = col_q;
              res_o.row    = 12'(h13 - 13'd1 - {1'b0, frow_q});
              res_o.last   = last_px;
              if (last_px) begin
                phase_d = PH_DONE;
              end else if (col_nxt == w13) begin
                // row padding is width mod 4 bytes for 3-byte pixels
                col_d = '0;
                pad_d = w13[1:0];
                if (w13[1:0] != 2'd0) begin
                  phase_d = PH_PAD;
                end else begin
                  frow_d = frow_q + 12'd1;
                end
              end else begin
                col_d = col_nxt[11:0];
              end
            end
          endcase
        end
        PH_PAD: begin
          pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0) begin
            frow_d  = frow_q + 12'd1;
            phase_d = PH_PIXELS;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      hdr_q    <= '0;
      magic_q  <= '0;
      offset_q <= '0;
      pos_q    <= '0;
      raw_w_q  <= '0;
      raw_h_q  <= '0;
      trip_q   <= '0;
      held_q   <= '0;
      col_q    <= '0;
      frow_q   <= '0;
      pad_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      magic_q  <= magic_d;
      offset_q <= offset_d;
      pos_q    <= pos_d;
      raw_w_q  <= raw_w_d;
      raw_h_q  <= raw_h_d;
      trip_q   <= trip_d;
      held_q   <= held_d;
      col_q    <= col_d;
      frow_q   <= frow_d;
      pad_q    <= pad_d;
    end
  end

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS) |-> ({1'b0, col_q} < w13))
    else $error("column beyond image width");

  a_pad_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAD) |-> (pad_q != 2'd0))
    else $error("pad phase with no pad bytes left");

  a_trip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trip_q != 2'd3)
    else $error("triplet index out of range");

endmodule

// ===== sv/b24argb_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
module b24argb_out_buf
  import b24argb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  b24argb_res_t push_data_i,
  output logic         space_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output b24argb_res_t out_data_o
);

  logic         out_v_q, out_v_d, sk_v_q, sk_v_d;
  b24argb_res_t out_q, out_d, sk_q, sk_d;

  assign space_o     = !sk_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    sk_v_d  = sk_v_q;
    sk_d    = sk_q;
    if (out_v_q && out_ready_i) begin
      out_v_d = sk_v_q;
      out_d   = sk_q;
      sk_v_d  = 1'b0;
    end
    if (push_i) begin
      if (!out_v_d) begin
        out_d   = push_data_i;
        out_v_d = 1'b1;
      end else begin
        sk_d   = push_data_i;
        sk_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid entry held with output register empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !sk_v_q)
    else $error("request pushed into full buffer");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_v_q && !out_ready_i) |=> (sk_v_q && out_v_q))
    else $error("stalled request not captured in skid register");

endmodule

// ===== sv/bmp24_stream_to_argb.sv =====
// Top level: 24-bit BMP byte stream to ARGB pixels with flipped row numbers.
// A result is registered in the output register, or in the skid register while that one is still held.
// Throughput: one byte per cycle; in_ready_o drops only when both the output
// register and the skid register hold results not yet taken.
// Reset (rst_ni low, asynchronous): parser idle, waiting for a start-of-file byte,
// result buffer empty.
module bmp24_stream_to_argb
  import b24argb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] pixel_argb_o,
  output logic [11:0] column_o,
  output logic [11:0] row_o,
  output logic        last_pixel_o,
  output logic [12:0] image_width_o,
  output logic [12:0] image_height_o
);

  logic         accept, res_valid, space;
  b24argb_res_t res, out_res;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  b24argb_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .start_of_file_i (start_of_file_i),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  b24argb_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign pixel_argb_o   = out_res.argb;
  assign column_o       = out_res.column;
  assign row_o          = out_res.row;
  assign last_pixel_o   = out_res.last;
  assign image_width_o  = out_res.width;
  assign image_height_o = out_res.height;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the 24-bit BMP stream decoder, with a byte-level predictor.
`timescale 1ns / 1ps

module testbench;
  import b24argb_pkg::*;

  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the result buffer
  localparam int STALL_LIMIT  = 3000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_BYTES   = 200;
  localparam int CALM_BYTES   = 120;   // past this, no idling on either side
  localparam int SHOW_LIMIT   = 40;

  // One test file: header fields, how many bytes to send and what follows.
  typedef struct {
    logic [15:0] magic;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    int          cut;    // bytes of the file to send, -1 for the whole image
    int          tail;   // trailing bytes after the file
    bit          typed;  // header result given in the row
    kind_e       kind;
  } bmp_case_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        start_of_file_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  result_kind_o;
  logic [31:0] pixel_argb_o;
  logic [11:0] column_o;
  logic [11:0] row_o;
  logic        last_pixel_o;
  logic [12:0] image_width_o;
  logic [12:0] image_height_o;

  // Side channel that travels with each byte request: a header result typed in the table.
  bit           typed_flag;
  b24argb_res_t typed_res;

  bit hold_req, hold_done, calm, gap_on;

  b24argb_res_t due_results[$];
  int mismatches, stall_cycles;
  int pixels_seen, headers_ok, header_errors;

  // Decoder state as predicted
  phase_e      ph;
  logic [5:0]  hdr_idx;
  logic [15:0] magic;
  logic [31:0] data_off, byte_pos, width_raw, height_raw, img_w, img_h;
  logic [1:0]  tri_idx, pad_left;
  logic [15:0] held_bg;
  logic [31:0] col_cnt, file_row;

  bmp24_stream_to_argb dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .start_of_file_i(start_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .pixel_argb_o   (pixel_argb_o),
    .column_o       (column_o),
    .row_o          (row_o),
    .last_pixel_o   (last_pixel_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_decoder();
    ph         = PH_IDLE;
    hdr_idx    = '0;
    magic      = '0;
    data_off   = '0;
    byte_pos   = '0;
    width_raw  = '0;
    height_raw = '0;
    img_w      = '0;
    img_h      = '0;
    tri_idx    = '0;
    held_bg    = '0;
    col_cnt    = '0;
    file_row   = '0;
    pad_left   = '0;
  endfunction

  // Returns 1 when the byte produces a result, which is then in r.
  function automatic bit bmp_decode_byte(input logic [7:0] b, input logic sof,
                                         output b24argb_res_t r);
    int          i;
    kind_e       k;
    logic [31:0] rw;
    bit          last_px;
    r = '0;
    if (sof) begin
      clear_decoder();
      ph = PH_HEADER;
    end
    case (ph)
      PH_HEADER: begin
        i = int'(hdr_idx);
        if (i < 2) magic = magic | (16'(b) << (8 * i));
        else if (i >= 10 && i < 14) data_off = data_off | (32'(b) << (8 * (i - 10)));
        else if (i >= 18 && i < 22) width_raw = width_raw | (32'(b) << (8 * (i - 18)));
        else if (i >= 22 && i < 26) height_raw = height_raw | (32'(b) << (8 * (i - 22)));
        hdr_idx  = 6'(i + 1);
        byte_pos = 32'(i + 1);
        if (32'(i + 1) < HDR_LEN) return 1'b0;
        img_w = width_raw;
        img_h = height_raw;
        // negative sizes have the top bit set and fail the upper bound
        if (magic != MAGIC_BM) k = KIND_BAD_MAGIC;
        else if (width_raw < 1 || width_raw > MAX_DIM || height_raw < 1 || height_raw > MAX_DIM)
          k = KIND_BAD_SIZE;
        else if (data_off < HDR_LEN) k = KIND_BAD_OFFSET;
        else k = KIND_HEADER_OK;
        if (k != KIND_HEADER_OK) ph = PH_DONE;
        else if (data_off == HDR_LEN) ph = PH_PIXELS;
        else ph = PH_SKIP;
        r.kind   = k;
        r.width  = width_raw[12:0];
        r.height = height_raw[12:0];
        return 1'b1;
      end
      PH_SKIP: begin
        byte_pos = byte_pos + 1;
        if (byte_pos == data_off) ph = PH_PIXELS;
        return 1'b0;
      end
      PH_PIXELS: begin
        if (tri_idx == 2'd0) begin
          held_bg = {8'h00, b};
          tri_idx = 2'd1;
          return 1'b0;
        end
        if (tri_idx == 2'd1) begin
          held_bg[15:8] = b;
          tri_idx = 2'd2;
          return 1'b0;
        end
        tri_idx = 2'd0;
        rw      = img_h - 1 - file_row;
        last_px = (file_row + 1 == img_h) && (col_cnt + 1 == img_w);
        r.kind   = KIND_PIXEL;
        r.argb   = {ALPHA, b, held_bg};
        r.column = col_cnt[11:0];
        r.row    = rw[11:0];
        r.last   = last_px;
        if (last_px) begin
          ph = PH_DONE;
        end else if (col_cnt + 1 == img_w) begin
          col_cnt  = '0;
          pad_left = img_w[1:0];
          if (pad_left != 2'd0) ph = PH_PAD;
          else file_row = file_row + 1;
        end else begin
          col_cnt = col_cnt + 1;
        end
        return 1'b1;
      end
      PH_PAD: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) begin
          file_row = file_row + 1;
          ph = PH_PIXELS;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int image_bytes(input logic [31:0] w, input logic [31:0] h,
                                     input logic [31:0] off);
    return int'(off) + int'(h) * (3 * int'(w) + int'(w & 32'd3));
  endfunction

  task automatic cmp_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Scoreboard: predict on each accepted byte, check each accepted result.
  always @(posedge clk_i) begin : scoreboard
    b24argb_res_t got, want;
    bit           has;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        has = bmp_decode_byte(data_byte_i, start_of_file_i, got);
        if (typed_flag) due_results.push_back(typed_res);
        else if (has) due_results.push_back(got);
      end
      if (out_valid_o && out_ready_i) begin
        if (result_kind_o == KIND_PIXEL) pixels_seen++;
        else if (result_kind_o == KIND_HEADER_OK) headers_ok++;
        else header_errors++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: unexpected result, expected none, actual kind %0d argb %0h",
                     $time, result_kind_o, pixel_argb_o);
        end else begin
          want = due_results.pop_front();
          cmp_field("result_kind", 32'(want.kind), 32'(result_kind_o));
          cmp_field("pixel_argb", want.argb, pixel_argb_o);
          cmp_field("column", 32'(want.column), 32'(column_o));
          cmp_field("row", 32'(want.row), 32'(row_o));
          cmp_field("last_pixel", 32'(want.last), 32'(last_pixel_o));
          cmp_field("image_width", 32'(want.width), 32'(image_width_o));
          cmp_field("image_height", 32'(want.height), 32'(image_height_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random bursts of back-pressure, one long hold-off on request, none when calm.
  initial begin : receiver
    int span;
    bit lazy;
    span = 0;
    lazy = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (!calm && lazy && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
      if (span == 0) begin
        span = $urandom_range(40, 200);
        lazy = ($urandom_range(0, 2) != 0);
      end else begin
        span--;
      end
    end
  end

  // Offer one byte request and wait until it is taken; returns at a falling edge.
  task automatic push_byte(input logic [7:0] b, input logic sof, input bit typed,
                           input b24argb_res_t t);
    if (!calm && gap_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    start_of_file_i <= sof;
    typed_flag      <= typed;
    typed_res       <= t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_file(input bmp_case_t c, output int sent);
    int           total;
    logic [7:0]   b;
    b24argb_res_t hdr;
    hdr        = '0;
    hdr.kind   = c.kind;
    hdr.width  = c.width[12:0];
    hdr.height = c.height[12:0];
    total  = (c.cut < 0) ? image_bytes(c.width, c.height, c.offset) : c.cut;
    gap_on = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < total; i++) begin
      if (i < 2) b = c.magic[8 * i +: 8];
      else if (i >= 10 && i < 14) b = c.offset[8 * (i - 10) +: 8];
      else if (i >= 18 && i < 22) b = c.width[8 * (i - 18) +: 8];
      else if (i >= 22 && i < 26) b = c.height[8 * (i - 22) +: 8];
      else b = 8'($urandom);
      push_byte(b, i == 0, c.typed && i == 53, hdr);
    end
    // trailing bytes are ignored by the block unless the file was cut short; now and then one restarts parsing
    for (int i = 0; i < c.tail; i++)
      push_byte(8'($urandom), $urandom_range(0, 15) == 0, 1'b0, hdr);
    sent = total;
  endtask

  initial begin : stimulus
    bmp_case_t cases[19];
    bmp_case_t c;
    int        n, files, dir_bytes, rand_bytes, pick;
    cases = '{
      '{MAGIC_BM, 32'd54, 32'd1, 32'd1, -1, 3, 1'b0, KIND_PIXEL},   // pixels right after header
      '{MAGIC_BM, 32'd58, 32'd3, 32'd2, -1, 0, 1'b0, KIND_PIXEL},
      '{MAGIC_BM, 32'd55, 32'd2, 32'd3, -1, 0, 1'b0, KIND_PIXEL},
      '{MAGIC_BM, 32'd54, 32'd4, 32'd2, -1, 1, 1'b0, KIND_PIXEL},   // no row padding
      '{MAGIC_BM, 32'd60, 32'd5, 32'd1, -1, 0, 1'b0, KIND_PIXEL},
      '{16'h424D, 32'd54, 32'd2, 32'd2, 54, 4, 1'b1, KIND_BAD_MAGIC},
      '{16'h0000, 32'd54, 32'd0, 32'd2, 54, 0, 1'b1, KIND_BAD_MAGIC}, // magic checked first
      '{MAGIC_BM, 32'd54, 32'd0, 32'd3, 54, 2, 1'b1, KIND_BAD_SIZE},
      '{MAGIC_BM, 32'd54, 32'd2, 32'hFFFF_FFFF, 54, 0, 1'b1, KIND_BAD_SIZE},
      '{MAGIC_BM, 32'd54, 32'd4097, 32'd1, 54, 0, 1'b1, KIND_BAD_SIZE},
      '{MAGIC_BM, 32'd53, 32'd1, 32'd1, 54, 3, 1'b1, KIND_BAD_OFFSET},
      '{MAGIC_BM, 32'd0, 32'd4096, 32'd4096, 54, 0, 1'b1, KIND_BAD_OFFSET},
      '{MAGIC_BM, 32'd54, 32'd4096, 32'd1, 84, 0, 1'b1, KIND_HEADER_OK}, // widest, cut short
      '{MAGIC_BM, 32'd56, 32'd1, 32'd4096, 96, 0, 1'b1, KIND_HEADER_OK}, // tallest, cut short
      '{MAGIC_BM, 32'hFFFF_FFFF, 32'd2, 32'd2, 110, 0, 1'b0, KIND_PIXEL}, // endless skip
      '{MAGIC_BM, 32'd54, 32'd3, 32'd3, 30, 0, 1'b0, KIND_PIXEL},   // restart inside header
      '{MAGIC_BM, 32'd54, 32'd3, 32'd3, 71, 0, 1'b0, KIND_PIXEL},   // restart inside image
      '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 54, 2, 1'b1, KIND_BAD_MAGIC},
      '{MAGIC_BM, 32'd54, 32'd7, 32'd3, -1, 0, 1'b0, KIND_PIXEL}
    };
    files = 0;
    dir_bytes = 0;
    rand_bytes = 0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    start_of_file_i = 1'b0;
    typed_flag = 1'b0;
    typed_res = '0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    calm = 1'b0;
    gap_on = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    pixels_seen = 0;
    headers_ok = 0;
    header_errors = 0;
    clear_decoder();
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // bytes before any start are ignored
    for (int i = 0; i < 5; i++) push_byte(8'($urandom), 1'b0, 1'b0, typed_res);

    foreach (cases[j]) begin
      send_file(cases[j], n);
      dir_bytes += n;
      files++;
    end

    hold_req = 1'b1;
    while (rand_bytes < RAND_BYTES) begin
      if (rand_bytes > CALM_BYTES) calm = 1'b1;
      c.magic  = MAGIC_BM;
      c.width  = $urandom_range(1, 9);
      c.height = $urandom_range(1, 5);
      c.offset = 32'd54 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
      c.cut    = -1;
      c.tail   = $urandom_range(0, 3);
      c.typed  = 1'b0;
      c.kind   = KIND_PIXEL;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        c.magic = 16'($urandom);
        c.cut = 54;
      end else if (pick < 15) begin
        case ($urandom_range(0, 3))
          0: c.width = '0;
          1: c.height = '0;
          2: c.width = 32'd4097 + $urandom_range(0, 60000);
          default: c.height = $urandom | 32'h8000_0000;
        endcase
        c.cut = 54;
      end else if (pick < 20) begin
        c.offset = $urandom_range(0, 53);
        c.cut = 54;
      end else if (pick < 30) begin
        c.cut = $urandom_range(1, image_bytes(c.width, c.height, c.offset) - 1);
      end
      send_file(c, n);
      rand_bytes += n;
      files++;
    end
    in_valid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d files, %0d bytes (%0d directed): %0d pixels, %0d good headers,",
             files, dir_bytes + rand_bytes, dir_bytes, pixels_seen, headers_ok);
    $display("%0d header errors, one %0d-cycle output hold-off, %0d mismatches.",
             header_errors, HOLD_CYCLES, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
